>>> sv/bilinear_wrap_clamp_sampler_defines.svh
// Assertion helpers shared by the sampler modules.
`ifndef BILINEAR_WRAP_CLAMP_SAMPLER_DEFINES_SVH
`define BILINEAR_WRAP_CLAMP_SAMPLER_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define BWCS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BWCS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

>>> sv/bwcs_pkg.sv
package bwcs_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int SIZE_W      = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int IDX_W       = 12;
  localparam int CHAN_W      = 24;
  localparam int NUM_CHAN    = 4;
  localparam int PIX_W       = CHAN_W * NUM_CHAN;
  localparam int SEL_W       = 2;
  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int ONE         = 1 << FRAC_W;
  localparam int HALF        = 1 << (FRAC_W - 1);
  localparam int PROD_W      = CHAN_W + FRAC_W + 2;
  localparam int NUM_TAPS    = 4;
  localparam int TAP_W       = $clog2(NUM_TAPS);
  localparam int QUEUE_DEPTH = 2;

  localparam int DEFAULT_WIDTH  = 64;
  localparam int DEFAULT_HEIGHT = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_LAST,
    BK_MUL_BOT,
    BK_ADD_BOT,
    BK_MUL_OUT,
    BK_DONE
  } back_state_e;

  // One classified item on its way from the front end to the back end.
  // A write uses addr[0] and pixel; a sample uses the four tap addresses,
  // the channel select and both weights.
  typedef struct packed {
    op_e                              op;
    logic [SEL_W-1:0]                 chan;
    logic [NUM_TAPS-1:0][ADDR_W-1:0]  addr;
    logic [PIX_W-1:0]                 pixel;
    logic [FRAC_W-1:0]                tx;
    logic [FRAC_W-1:0]                ty;
  } entry_t;

  function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] raw,
                                                  input int maxv);
    logic [SIZE_W-1:0] res;
    if (raw == '0) begin
      res = SIZE_W'(1);
    end else if (32'(raw) > maxv) begin
      res = SIZE_W'(maxv);
    end else begin
      res = raw;
    end
    return res;
  endfunction

  function automatic logic signed [CHAN_W-1:0] chan_pick(input logic [PIX_W-1:0] pix,
                                                         input logic [SEL_W-1:0] sel);
    return pix[sel*CHAN_W +: CHAN_W];
  endfunction

endpackage

>>> sv/bwcs_ram.sv
module bwcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bwcs_front.sv
module bwcs_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic [bwcs_pkg::IDX_W-1:0]          pixel_index_i,
  input  logic signed [bwcs_pkg::CHAN_W-1:0]  red_value_i,
  input  logic signed [bwcs_pkg::CHAN_W-1:0]  green_value_i,
  input  logic signed [bwcs_pkg::CHAN_W-1:0]  blue_value_i,
  input  logic signed [bwcs_pkg::CHAN_W-1:0]  alpha_value_i,
  input  logic signed [bwcs_pkg::COORD_W-1:0] u_coord_i,
  input  logic signed [bwcs_pkg::COORD_W-1:0] v_coord_i,
  input  logic [bwcs_pkg::SEL_W-1:0]          channel_i,
  input  logic [bwcs_pkg::SIZE_W-1:0]         width_i,
  input  logic [bwcs_pkg::SIZE_W-1:0]         height_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output bwcs_pkg::entry_t                    push_entry_o
);

  localparam int XS_W = bwcs_pkg::FRAC_W + bwcs_pkg::SIZE_W + 1;
  localparam int YS_W = bwcs_pkg::FRAC_W + bwcs_pkg::SIZE_W + 2;
  localparam int XI_W = bwcs_pkg::SIZE_W + 2;

  // Clamped row times width plus wrapped column.
  function automatic logic [bwcs_pkg::ADDR_W-1:0] tap_addr(
      input logic signed [XI_W-1:0] row,
      input logic signed [XI_W-1:0] col,
      input logic [bwcs_pkg::SIZE_W-1:0] w);
    logic [bwcs_pkg::ROW_W-1:0] r;
    logic [bwcs_pkg::COL_W-1:0] c;
    logic [bwcs_pkg::ROW_W+bwcs_pkg::SIZE_W:0] full;
    r = bwcs_pkg::ROW_W'(row);
    c = bwcs_pkg::COL_W'(col);
    full = (bwcs_pkg::ROW_W+bwcs_pkg::SIZE_W+1)'(r * w)
         + (bwcs_pkg::ROW_W+bwcs_pkg::SIZE_W+1)'(c);
    return bwcs_pkg::ADDR_W'(full);
  endfunction

  function automatic logic signed [XI_W-1:0] row_clamp(input logic signed [XI_W-1:0] y,
                                                       input logic signed [XI_W-1:0] hm1);
    logic signed [XI_W-1:0] res;
    if (y < 0) begin
      res = '0;
    end else if (y > hm1) begin
      res = hm1;
    end else begin
      res = y;
    end
    return res;
  endfunction

  logic [bwcs_pkg::FRAC_W-1:0]               fu;
  logic [bwcs_pkg::FRAC_W:0]                 fv;
  logic [bwcs_pkg::FRAC_W+bwcs_pkg::SIZE_W-1:0] xp;
  logic [bwcs_pkg::FRAC_W+bwcs_pkg::SIZE_W:0]   yp;
  logic signed [XS_W-1:0]                    xs;
  logic signed [YS_W-1:0]                    ys;
  logic                                      s1_free;

  logic                                      s1_valid_q;
  bwcs_pkg::op_e                             s1_op_q;
  logic [bwcs_pkg::SEL_W-1:0]                s1_chan_q;
  logic [bwcs_pkg::IDX_W-1:0]                s1_idx_q;
  logic [bwcs_pkg::PIX_W-1:0]                s1_pix_q;
  logic signed [bwcs_pkg::SIZE_W:0]          s1_x0_q;
  logic signed [XI_W-1:0]                    s1_y0_q;
  logic [bwcs_pkg::FRAC_W-1:0]               s1_tx_q;
  logic [bwcs_pkg::FRAC_W-1:0]               s1_ty_q;

  logic signed [XI_W-1:0] x0e, x1, wx0, wx1, we, wm1, hm1, y1, cy0, cy1;
  logic                   idx_ok;
  logic                   need_push;

  // Coordinate scaling: u keeps its fraction, v is clamped to [0, 1].
  always_comb begin
    fu = u_coord_i[bwcs_pkg::FRAC_W-1:0];
    if (v_coord_i[bwcs_pkg::COORD_W-1]) begin
      fv = '0;
    end else if (v_coord_i[bwcs_pkg::COORD_W-2:0] > (bwcs_pkg::COORD_W-1)'(bwcs_pkg::ONE)) begin
      fv = (bwcs_pkg::FRAC_W+1)'(bwcs_pkg::ONE);
    end else begin
      fv = v_coord_i[bwcs_pkg::FRAC_W:0];
    end
    xp = fu * width_i;
    yp = fv * height_i;
    xs = $signed({1'b0, xp}) - $signed(XS_W'(bwcs_pkg::HALF));
    ys = $signed({1'b0, yp}) - $signed(YS_W'(bwcs_pkg::HALF));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_op_q   <= bwcs_pkg::op_e'(op_i);
      s1_chan_q <= channel_i;
      s1_idx_q  <= pixel_index_i;
      s1_pix_q  <= {alpha_value_i, blue_value_i, green_value_i, red_value_i};
      s1_x0_q   <= xs[XS_W-1:bwcs_pkg::FRAC_W];
      s1_y0_q   <= ys[YS_W-1:bwcs_pkg::FRAC_W];
      s1_tx_q   <= xs[bwcs_pkg::FRAC_W-1:0];
      s1_ty_q   <= ys[bwcs_pkg::FRAC_W-1:0];
    end
  end

  // Neighbor columns wrap around the width; neighbor rows clamp to the image.
  always_comb begin
    x0e = {s1_x0_q[bwcs_pkg::SIZE_W], s1_x0_q};
    we  = $signed({2'b00, width_i});
    wm1 = we - $signed(XI_W'(1));
    hm1 = $signed({2'b00, height_i}) - $signed(XI_W'(1));
    wx0 = x0e[XI_W-1] ? wm1 : x0e;
    x1  = x0e + $signed(XI_W'(1));
    wx1 = (x1 == we) ? '0 : x1;
    y1  = s1_y0_q + $signed(XI_W'(1));
    cy0 = row_clamp(s1_y0_q, hm1);
    cy1 = row_clamp(y1, hm1);
  end

  always_comb begin
    idx_ok    = 32'(s1_idx_q) < bwcs_pkg::STORE_DEPTH;
    need_push = (s1_op_q == bwcs_pkg::OP_SAMPLE) || idx_ok;

    push_entry_o.op      = s1_op_q;
    push_entry_o.chan    = s1_chan_q;
    push_entry_o.addr[0] = (s1_op_q == bwcs_pkg::OP_SAMPLE) ? tap_addr(cy0, wx0, width_i)
                                                            : bwcs_pkg::ADDR_W'(s1_idx_q);
    push_entry_o.addr[1] = tap_addr(cy0, wx1, width_i);
    push_entry_o.addr[2] = tap_addr(cy1, wx0, width_i);
    push_entry_o.addr[3] = tap_addr(cy1, wx1, width_i);
    push_entry_o.pixel   = s1_pix_q;
    push_entry_o.tx      = s1_tx_q;
    push_entry_o.ty      = s1_ty_q;

    push_valid_o = s1_valid_q && need_push;
    // A write beyond the store is dropped here without reaching the queue.
    s1_free      = !s1_valid_q || !need_push || push_ready_i;
    in_stall_o   = !s1_free;
  end

endmodule

>>> sv/bwcs_queue.sv
`include "bilinear_wrap_clamp_sampler_defines.svh"

module bwcs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  bwcs_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output bwcs_pkg::entry_t pop_entry_o
);

  localparam int PTR_W = (bwcs_pkg::QUEUE_DEPTH > 1) ? $clog2(bwcs_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(bwcs_pkg::QUEUE_DEPTH + 1);

  bwcs_pkg::entry_t   mem_q [bwcs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               push, pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] res;
    if (32'(p) == bwcs_pkg::QUEUE_DEPTH - 1) begin
      res = '0;
    end else begin
      res = p + PTR_W'(1);
    end
    return res;
  endfunction

  assign push_ready_o = 32'(count_q) != bwcs_pkg::QUEUE_DEPTH;
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `BWCS_ASSERT(a_count_bound, clk_i, rst_ni, 32'(count_q) <= bwcs_pkg::QUEUE_DEPTH, "queue count beyond depth")
  `BWCS_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push && !pop, count_q == $past(count_q) + CNT_W'(1), "push without pop did not grow the queue")

endmodule

>>> sv/bwcs_back.sv
`include "bilinear_wrap_clamp_sampler_defines.svh"

module bwcs_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pop_valid_i,
  input  bwcs_pkg::entry_t                   pop_entry_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bwcs_pkg::CHAN_W-1:0] sample_value_o
);

  localparam int DIFF_W = bwcs_pkg::CHAN_W + 1;
  localparam int Q_W    = bwcs_pkg::PROD_W - bwcs_pkg::FRAC_W;

  // a + floor(p / 2^16); the sum always lands between the two endpoints.
  function automatic logic signed [bwcs_pkg::CHAN_W-1:0] lerp_add(
      input logic signed [bwcs_pkg::CHAN_W-1:0] a,
      input logic signed [bwcs_pkg::PROD_W-1:0] p);
    logic signed [Q_W-1:0] q;
    logic signed [Q_W-1:0] s;
    q = p[bwcs_pkg::PROD_W-1:bwcs_pkg::FRAC_W];
    s = q + Q_W'(a);
    return s[bwcs_pkg::CHAN_W-1:0];
  endfunction

  bwcs_pkg::back_state_e state_q, state_d;
  logic [bwcs_pkg::TAP_W-1:0] cnt_q, cnt_d;
  bwcs_pkg::entry_t           job_q;

  logic signed [bwcs_pkg::CHAN_W-1:0] c00_q, c10_q, c01_q, c11_q, top_q, bot_q;
  logic signed [bwcs_pkg::PROD_W-1:0] prod_q, mul_p;
  logic signed [DIFF_W-1:0]           mul_diff;
  logic [bwcs_pkg::FRAC_W-1:0]        mul_t;
  logic                               prod_en;

  logic                               out_valid_q;
  logic signed [bwcs_pkg::CHAN_W-1:0] out_value_q;
  logic                               out_load;

  logic                               ram_en, ram_we;
  logic [bwcs_pkg::ADDR_W-1:0]        ram_addr;
  logic [bwcs_pkg::PIX_W-1:0]         ram_rdata;
  logic signed [bwcs_pkg::CHAN_W-1:0] tap_val;

  bwcs_ram #(
    .WIDTH(bwcs_pkg::PIX_W),
    .DEPTH(bwcs_pkg::STORE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(pop_entry_i.pixel),
    .rdata_o(ram_rdata)
  );

  assign tap_val  = bwcs_pkg::chan_pick(ram_rdata, job_q.chan);
  assign out_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      bwcs_pkg::BK_IDLE: begin
        if (pop_valid_i && pop_entry_i.op == bwcs_pkg::OP_SAMPLE) begin
          state_d = bwcs_pkg::BK_FETCH;
          cnt_d   = bwcs_pkg::TAP_W'(1);
        end
      end
      bwcs_pkg::BK_FETCH: begin
        cnt_d = cnt_q + bwcs_pkg::TAP_W'(1);
        if (32'(cnt_q) == bwcs_pkg::NUM_TAPS - 1) begin
          state_d = bwcs_pkg::BK_LAST;
        end
      end
      bwcs_pkg::BK_LAST:    state_d = bwcs_pkg::BK_MUL_BOT;
      bwcs_pkg::BK_MUL_BOT: state_d = bwcs_pkg::BK_ADD_BOT;
      bwcs_pkg::BK_ADD_BOT: state_d = bwcs_pkg::BK_MUL_OUT;
      bwcs_pkg::BK_MUL_OUT: state_d = bwcs_pkg::BK_DONE;
      bwcs_pkg::BK_DONE: begin
        if (out_load) begin
          state_d = bwcs_pkg::BK_IDLE;
        end
      end
      default: state_d = bwcs_pkg::BK_IDLE;
    endcase
  end

  // The single memory port serves one write, or one tap read, per cycle.
  always_comb begin
    pop_o    = 1'b0;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = job_q.addr[cnt_q];
    mul_diff = DIFF_W'(c10_q) - DIFF_W'(c00_q);
    mul_t    = job_q.tx;
    prod_en  = 1'b0;
    unique case (state_q)
      bwcs_pkg::BK_IDLE: begin
        pop_o    = pop_valid_i;
        ram_en   = pop_valid_i;
        ram_we   = pop_valid_i && pop_entry_i.op == bwcs_pkg::OP_WRITE;
        ram_addr = pop_entry_i.addr[0];
      end
      bwcs_pkg::BK_FETCH: begin
        ram_en  = 1'b1;
        prod_en = 32'(cnt_q) == bwcs_pkg::NUM_TAPS - 1;
      end
      bwcs_pkg::BK_MUL_BOT: begin
        mul_diff = DIFF_W'(c11_q) - DIFF_W'(c01_q);
        prod_en  = 1'b1;
      end
      bwcs_pkg::BK_MUL_OUT: begin
        mul_diff = DIFF_W'(bot_q) - DIFF_W'(top_q);
        mul_t    = job_q.ty;
        prod_en  = 1'b1;
      end
      bwcs_pkg::BK_LAST, bwcs_pkg::BK_ADD_BOT, bwcs_pkg::BK_DONE: begin
      end
      default: begin
      end
    endcase
    mul_p = mul_diff * $signed({1'b0, mul_t});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bwcs_pkg::BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == bwcs_pkg::BK_DONE && out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Read data arrives in the cycle after its address, so each fetch step keeps the
  // tap requested in the step before it.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= pop_entry_i;
    end
    if (state_q == bwcs_pkg::BK_FETCH) begin
      unique case (cnt_q)
        bwcs_pkg::TAP_W'(1): c00_q <= tap_val;
        bwcs_pkg::TAP_W'(2): c10_q <= tap_val;
        bwcs_pkg::TAP_W'(3): c01_q <= tap_val;
        default: ;
      endcase
    end
    if (state_q == bwcs_pkg::BK_LAST) begin
      c11_q <= tap_val;
      top_q <= lerp_add(c00_q, prod_q);
    end
    if (state_q == bwcs_pkg::BK_ADD_BOT) begin
      bot_q <= lerp_add(c01_q, prod_q);
    end
    if (prod_en) begin
      prod_q <= mul_p;
    end
    if (state_q == bwcs_pkg::BK_DONE && out_load) begin
      out_value_q <= lerp_add(top_q, prod_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = out_value_q;

  `BWCS_ASSERT(a_write_idle, clk_i, rst_ni, ram_we |-> state_q == bwcs_pkg::BK_IDLE, "pixel write outside idle")
  `BWCS_ASSERT(a_fetch_len, clk_i, rst_ni, pop_o && pop_entry_i.op == bwcs_pkg::OP_SAMPLE |-> ##4 state_q == bwcs_pkg::BK_LAST, "sample fetch did not take four cycles")
  `BWCS_ASSERT_NEXT(a_done_hold, clk_i, rst_ni, state_q == bwcs_pkg::BK_DONE && !out_load, state_q == bwcs_pkg::BK_DONE, "finished sample left before the output register was free")

endmodule

>>> sv/bilinear_wrap_clamp_sampler.sv
// Bilinear sampler over one four-channel image, signed Q8.16 per channel.
// Input channel: in_valid_i / in_stall_o with op_i selecting a pixel write
// (pixel_index_i plus four channel values) or a sample (u_coord_i, v_coord_i
// in Q16.16 and channel_i). U wraps to its fraction, v clamps to [0, 1].
// Output channel: out_valid_o / out_stall_i carries sample_value_o, one beat
// per sample beat; writes produce no output beat.
// Configuration: cfg_valid_i / cfg_ready_o, cfg_index_i 0 for width and 1 for
// height, cfg_data_i the size; other indexes are ignored. Write it only while idle.
// Timing: the front end takes one beat per cycle, while in_stall_o is low, into
// a two-entry queue. The back end owns the single-port pixel memory: it writes
// a pixel as it pops it; a sample runs through four tap reads on the one port,
// then three interpolations on one shared multiplier, before the back end pops
// the next item.
// Reset: sizes return to 64 by 64 and the queue empties; pixel contents stay
// undefined until written.
// A stalled output beat holds in the output register; the back end waits with
// its next result, the queue fills, and then in_stall_o rises.
module bilinear_wrap_clamp_sampler (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  op_i,
  input  logic [bwcs_pkg::IDX_W-1:0]            pixel_index_i,
  input  logic signed [bwcs_pkg::CHAN_W-1:0]    red_value_i,
  input  logic signed [bwcs_pkg::CHAN_W-1:0]    green_value_i,
  input  logic signed [bwcs_pkg::CHAN_W-1:0]    blue_value_i,
  input  logic signed [bwcs_pkg::CHAN_W-1:0]    alpha_value_i,
  input  logic signed [bwcs_pkg::COORD_W-1:0]   u_coord_i,
  input  logic signed [bwcs_pkg::COORD_W-1:0]   v_coord_i,
  input  logic [bwcs_pkg::SEL_W-1:0]            channel_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bwcs_pkg::CHAN_W-1:0]    sample_value_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bwcs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bwcs_pkg::SIZE_W-1:0]           cfg_data_i
);

  logic [bwcs_pkg::SIZE_W-1:0] width_q, height_q;
  logic [bwcs_pkg::SIZE_W-1:0] eff_width, eff_height;

  logic             push_valid, push_ready;
  bwcs_pkg::entry_t push_entry;
  logic             pop_valid, pop;
  bwcs_pkg::entry_t pop_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bwcs_pkg::SIZE_W'(bwcs_pkg::DEFAULT_WIDTH);
      height_q <= bwcs_pkg::SIZE_W'(bwcs_pkg::DEFAULT_HEIGHT);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == bwcs_pkg::CFG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == bwcs_pkg::CFG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  assign eff_width  = bwcs_pkg::sat_size(width_q, bwcs_pkg::MAX_WIDTH);
  assign eff_height = bwcs_pkg::sat_size(height_q, bwcs_pkg::MAX_HEIGHT);

  bwcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .pixel_index_i(pixel_index_i),
    .red_value_i  (red_value_i),
    .green_value_i(green_value_i),
    .blue_value_i (blue_value_i),
    .alpha_value_i(alpha_value_i),
    .u_coord_i    (u_coord_i),
    .v_coord_i    (v_coord_i),
    .channel_i    (channel_i),
    .width_i      (eff_width),
    .height_i     (eff_height),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  bwcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_entry_i(push_entry),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_entry_o (pop_entry)
  );

  bwcs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_entry_i   (pop_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_value_o(sample_value_o)
  );

endmodule

>>> sim/bwcs_sample_checker.sv
module bwcs_sample_checker
  import bwcs_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        op_i,
  input  logic [IDX_W-1:0]            pixel_index_i,
  input  logic signed [CHAN_W-1:0]    red_value_i,
  input  logic signed [CHAN_W-1:0]    green_value_i,
  input  logic signed [CHAN_W-1:0]    blue_value_i,
  input  logic signed [CHAN_W-1:0]    alpha_value_i,
  input  logic signed [COORD_W-1:0]   u_coord_i,
  input  logic signed [COORD_W-1:0]   v_coord_i,
  input  logic [SEL_W-1:0]            channel_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic signed [CHAN_W-1:0]    sample_value_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [SIZE_W-1:0]           cfg_data_i,
  output int                          mismatch_count_o,
  output int                          open_samples_o
);

  // Channel 0 sits in the low bits of each stored pixel.
  logic [PIX_W-1:0]           texel_mem [STORE_DEPTH];
  logic [SIZE_W-1:0]          img_w;
  logic [SIZE_W-1:0]          img_h;
  logic signed [CHAN_W-1:0]   expected_samples [$];
  logic signed [CHAN_W-1:0]   want;
  int                         mismatches = 0;
  int                         pending = 0;
  int                         beats_out = 0;

  assign mismatch_count_o = mismatches;
  assign open_samples_o   = pending;

  task automatic report_mismatch(input string msg);
    $display("checker: %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic longint eff_dim(input logic [SIZE_W-1:0] raw, input int limit);
    if (raw == '0) return 1;
    if (int'(raw) > limit) return limit;
    return longint'(raw);
  endfunction

  // Columns wrap around the width, rows clamp to the image.
  function automatic longint texel_at(input longint col, input longint row, input longint w,
                                      input longint h, input logic [SEL_W-1:0] ch);
    longint c;
    longint r;
    logic [PIX_W-1:0] pix;
    c = col % w;
    if (c < 0) c += w;
    r = row;
    if (r < 0) r = 0;
    if (r > h - 1) r = h - 1;
    pix = texel_mem[r * w + c];
    return longint'($signed(pix[ch*CHAN_W +: CHAN_W]));
  endfunction

  // The arithmetic shift floors the weighted product toward minus infinity.
  function automatic longint blend(input longint a, input longint b, input longint t);
    return a + (((b - a) * t) >>> FRAC_W);
  endfunction

  function automatic logic signed [CHAN_W-1:0] filtered_texel(
      input logic [COORD_W-1:0] u, input logic signed [COORD_W-1:0] v,
      input logic [SEL_W-1:0] ch);
    longint w;
    longint h;
    longint fv;
    longint x;
    longint y;
    longint x0;
    longint y0;
    longint tx;
    longint ty;
    longint top;
    longint bottom;
    longint res;
    w = eff_dim(img_w, MAX_WIDTH);
    h = eff_dim(img_h, MAX_HEIGHT);
    fv = v;
    if (fv < 0) fv = 0;
    if (fv > ONE) fv = ONE;
    x = longint'(u[FRAC_W-1:0]) * w - HALF;
    y = fv * h - HALF;
    x0 = x >>> FRAC_W;
    y0 = y >>> FRAC_W;
    tx = x & (ONE - 1);
    ty = y & (ONE - 1);
    top    = blend(texel_at(x0, y0, w, h, ch), texel_at(x0 + 1, y0, w, h, ch), tx);
    bottom = blend(texel_at(x0, y0 + 1, w, h, ch), texel_at(x0 + 1, y0 + 1, w, h, ch), tx);
    res = blend(top, bottom, ty);
    return res[CHAN_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_samples.delete();
      img_w   <= SIZE_W'(DEFAULT_WIDTH);
      img_h   <= SIZE_W'(DEFAULT_HEIGHT);
      pending <= 0;
    end else begin
      // An output beat can never belong to a sample taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        beats_out++;
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("output beat %0d with no sample waiting, value %h",
                                    beats_out, sample_value_i));
        end else begin
          want = expected_samples.pop_front();
          if (sample_value_i !== want) begin
            report_mismatch($sformatf("output beat %0d: sample_value %h, expected %h",
                                      beats_out, sample_value_i, want));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_WRITE) begin
          texel_mem[pixel_index_i] <= {alpha_value_i, blue_value_i, green_value_i,
                                       red_value_i};
        end else begin
          expected_samples.push_back(filtered_texel(u_coord_i, v_coord_i, channel_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_IMAGE_WIDTH) begin
          img_w <= cfg_data_i;
        end else if (cfg_index_i == CFG_IMAGE_HEIGHT) begin
          img_h <= cfg_data_i;
        end
      end
      pending <= expected_samples.size();
    end
  end

endmodule

>>> sim/tb.sv
module tb;
  import bwcs_pkg::*;

  localparam int RAND_ITEMS    = 36;
  localparam int FIXED_PHASES  = 8;
  localparam int NUM_PHASES    = 11;
  localparam int HOLD_PHASE    = 3;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_SAMPLES  = 60;
  localparam int SETTLE_CYCLES = 32;
  localparam int RUN_LIMIT     = 4_000_000;
  // Every size used keeps width times height within this many loaded pixels,
  // so no sample reaches a pixel that was never written.
  localparam int FILL_PIXELS   = 1024;

  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_HI = 2'd3;
  localparam logic signed [CHAN_W-1:0] CHAN_MIN = {1'b1, {(CHAN_W-1){1'b0}}};
  localparam logic signed [CHAN_W-1:0] CHAN_MAX = {1'b0, {(CHAN_W-1){1'b1}}};

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  op_e                        op = OP_WRITE;
  logic [IDX_W-1:0]           pixel_index = '0;
  logic signed [CHAN_W-1:0]   red = '0;
  logic signed [CHAN_W-1:0]   green = '0;
  logic signed [CHAN_W-1:0]   blue = '0;
  logic signed [CHAN_W-1:0]   alpha = '0;
  logic signed [COORD_W-1:0]  u_coord = '0;
  logic signed [COORD_W-1:0]  v_coord = '0;
  logic [SEL_W-1:0]           channel = '0;
  logic                       out_stall = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [SIZE_W-1:0]          cfg_data = '0;
  logic                       in_stall;
  logic                       out_valid;
  logic signed [CHAN_W-1:0]   sample_value;
  logic                       cfg_ready;
  int                         mismatch_count;
  int                         open_samples;

  bit send_fast = 1'b0;
  bit rush = 1'b0;
  int hold_len = 0;

  logic [SIZE_W-1:0] phase_w [FIXED_PHASES] = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd1, 7'd5,
                                                 7'd37, 7'd16};
  logic [SIZE_W-1:0] phase_h [FIXED_PHASES] = '{7'd1, 7'd0, 7'd1, 7'd16, 7'd127, 7'd3,
                                                 7'd27, 7'd64};

  bilinear_wrap_clamp_sampler u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .pixel_index_i  (pixel_index),
    .red_value_i    (red),
    .green_value_i  (green),
    .blue_value_i   (blue),
    .alpha_value_i  (alpha),
    .u_coord_i      (u_coord),
    .v_coord_i      (v_coord),
    .channel_i      (channel),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sample_value_o (sample_value),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  bwcs_sample_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .op_i             (op),
    .pixel_index_i    (pixel_index),
    .red_value_i      (red),
    .green_value_i    (green),
    .blue_value_i     (blue),
    .alpha_value_i    (alpha),
    .u_coord_i        (u_coord),
    .v_coord_i        (v_coord),
    .channel_i        (channel),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .sample_value_i   (sample_value),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .open_samples_o   (open_samples)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic signed [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return CHAN_MIN;
      1: return CHAN_MAX;
      2: return '0;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_u();
    case ($urandom_range(0, 5))
      0: return {16'($urandom), 16'h0000};
      1: return {16'($urandom), 16'hFFFF};
      2: return {16'($urandom), 16'h8000};
      default: return $urandom;
    endcase
  endfunction

  // Mostly inside [0, 1], with the clamped regions on both sides.
  function automatic logic signed [COORD_W-1:0] rand_v();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONE;
      2: return $urandom;
      3: return $urandom | 32'h8000_0000;
      4: return ONE + $urandom_range(1, 255);
      default: return $urandom_range(0, ONE);
    endcase
  endfunction

  // Stays at the accepting edge on return, so a back-to-back beat keeps valid high.
  task automatic send_beat(input op_e kind, input logic [IDX_W-1:0] idx,
                           input logic signed [CHAN_W-1:0] r, input logic signed [CHAN_W-1:0] g,
                           input logic signed [CHAN_W-1:0] b, input logic signed [CHAN_W-1:0] a,
                           input logic signed [COORD_W-1:0] u,
                           input logic signed [COORD_W-1:0] v, input logic [SEL_W-1:0] ch);
    int gap;
    if ($urandom_range(0, 31) == 0) send_fast = !send_fast;
    gap = (rush || send_fast) ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    op          <= kind;
    pixel_index <= idx;
    red         <= r;
    green       <= g;
    blue        <= b;
    alpha       <= a;
    u_coord     <= u;
    v_coord     <= v;
    channel     <= ch;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_write(input int idx, input logic signed [CHAN_W-1:0] r,
                            input logic signed [CHAN_W-1:0] g,
                            input logic signed [CHAN_W-1:0] b,
                            input logic signed [CHAN_W-1:0] a);
    send_beat(OP_WRITE, IDX_W'(idx), r, g, b, a, $urandom, $urandom,
              SEL_W'($urandom_range(0, 3)));
  endtask

  task automatic send_sample(input logic signed [COORD_W-1:0] u,
                             input logic signed [COORD_W-1:0] v, input int ch);
    send_beat(OP_SAMPLE, IDX_W'($urandom), rand_chan(), rand_chan(), rand_chan(),
              rand_chan(), u, v, SEL_W'(ch));
  endtask

  // Samples stay inside the loaded region, so random writes may land anywhere.
  task automatic random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        send_write($urandom_range(0, STORE_DEPTH - 1), rand_chan(), rand_chan(),
                   rand_chan(), rand_chan());
      end else begin
        send_sample(rand_u(), rand_v(), $urandom_range(0, 3));
      end
    end
  endtask

  // Writes give no output beat, so the settle time covers any still in the block.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (open_samples != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic program_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                               input logic [CFG_IDX_W-1:0] spare);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(spare, SIZE_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    int wait_len;
    @(posedge rst_ni);
    forever begin
      if (hold_len != 0) begin
        wait_len = hold_len;
        hold_len = 0;
      end else begin
        wait_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end
      if (wait_len != 0) begin
        out_stall <= 1'b1;
        repeat (wait_len) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    int h_top;
    @(posedge rst_ni);
    @(posedge clk_i);

    for (int i = 0; i < FILL_PIXELS; i++) begin
      send_write(i, rand_chan(), rand_chan(), rand_chan(), rand_chan());
    end

    // Extreme pixels at both ends of the loaded region and at the first row's wrap seam.
    send_write(0, CHAN_MIN, CHAN_MAX, CHAN_MIN, CHAN_MAX);
    send_write(FILL_PIXELS - 1, CHAN_MAX, CHAN_MIN, CHAN_MAX, CHAN_MIN);
    send_write(MAX_WIDTH - 1, CHAN_MAX, CHAN_MAX, CHAN_MIN, CHAN_MIN);
    send_write(MAX_WIDTH, '0, CHAN_MAX, '0, CHAN_MIN);
    drain();
    program_sizes(SIZE_W'(MAX_WIDTH), SIZE_W'(FILL_PIXELS / MAX_WIDTH), CFG_SPARE_LO);
    for (int ch = 0; ch < NUM_CHAN; ch++) send_sample('0, '0, ch);
    send_sample(32'h0000_FFFF, ONE, 0);
    send_sample(32'h8000_0000, 32'h8000_0000, 1);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 2);
    send_sample(32'h0000_0200, 32'h0000_0100, 3);
    send_sample(32'hFFFF_FE00, 32'h0000_FF00, 0);
    send_sample(32'h0000_8000, 32'h0000_8000, 1);
    send_sample(32'h1234_5678, 32'hFFFF_FFFF, 2);
    send_sample(32'h0000_0001, 32'h0001_0001, 3);

    random_items(RAND_ITEMS);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p < FIXED_PHASES) begin
        w = phase_w[p];
        h = phase_h[p];
      end else begin
        w = SIZE_W'($urandom_range(1, MAX_WIDTH));
        h_top = FILL_PIXELS / int'(w);
        if (h_top > MAX_HEIGHT) h_top = MAX_HEIGHT;
        h = SIZE_W'($urandom_range(1, h_top));
      end
      program_sizes(w, h, p[0] ? CFG_SPARE_HI : CFG_SPARE_LO);
      if (p == HOLD_PHASE) begin
        // The receiver sits out a long stretch while samples keep coming.
        hold_len = HOLD_CYCLES;
        rush = 1'b1;
        repeat (HOLD_SAMPLES) send_sample(rand_u(), rand_v(), $urandom_range(0, 3));
        rush = 1'b0;
      end
      random_items(RAND_ITEMS);
    end

    drain();
    if (mismatch_count == 0 && open_samples == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/bwcs_pkg.sv
sv/bwcs_ram.sv
sv/bwcs_front.sv
sv/bwcs_queue.sv
sv/bwcs_back.sv
sv/bilinear_wrap_clamp_sampler.sv
sim/bwcs_sample_checker.sv
sim/tb.sv
